>>> rtl/dgea_pkg.sv
`timescale 1ns / 1ps

package dgea_pkg;

	// Default build parameters
	localparam int DEF_PAIRS_PER_BATCH = 8;
	localparam int DEF_SAMPLE_BITS     = 12;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 12;
	localparam int LEVEL_W     = 12;
	localparam int WEIGHT_W    = 8;

	// Output widths
	localparam int ENERGY_W = 64;
	localparam int COUNT_W  = 32;

	// Register reset values
	localparam logic [LEVEL_W-1:0]  RST_LOW_GAIN_THRESHOLD = 12'd390;
	localparam logic [LEVEL_W-1:0]  RST_SETTLE_SPAN        = 12'd5;
	localparam logic [WEIGHT_W-1:0] RST_LOW_GAIN_WEIGHT    = 8'd21;
	localparam logic [WEIGHT_W-1:0] RST_HIGH_GAIN_WEIGHT   = 8'd2;

	// Register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LOW_GAIN_THRESHOLD = 4'd0,
		CFG_SETTLE_SPAN        = 4'd1,
		CFG_LOW_GAIN_WEIGHT    = 4'd2,
		CFG_HIGH_GAIN_WEIGHT   = 4'd3
	} cfg_index_t;

endpackage

>>> rtl/dual_gain_energy_accumulator_core.sv
`timescale 1ns / 1ps

// Dual-gain energy accumulator. Each input beat carries a high-gain and a
// low-gain sample plus a conversion-done flag and produces exactly one result
// beat: weighted energy (low total * low weight + high total * high weight,
// mod 2^64), the count of counted pairs and the calibrated flag. Beats are
// grouped in batches of PAIRS_PER_BATCH; until a batch settles (high-gain
// max - min below settle_span) each batch reloads both offsets with its mean
// and nothing is counted. Throughput is one beat per clock while out_ready is
// high. The accepting edge updates offsets, totals and count; when the beat
// advances, the output register takes the weight multiply of the 64-bit
// totals. The in_ready stalls only when both the state stage and the output
// register hold beats and out_ready is low. Configuration is written through
// cfg_wr_en/cfg_wr_index/cfg_wr_data and must only change while idle.
module dual_gain_energy_accumulator_core
	import dgea_pkg::*;
#(
	parameter int PAIRS_PER_BATCH = DEF_PAIRS_PER_BATCH,
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] high_gain_sample,
	input  logic [SAMPLE_BITS-1:0] low_gain_sample,
	input  logic                   conversion_done,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ENERGY_W-1:0]    energy_count,
	output logic [COUNT_W-1:0]     sample_total,
	output logic                   is_calibrated
);

	localparam int POS_W  = (PAIRS_PER_BATCH > 1) ? $clog2(PAIRS_PER_BATCH) : 1;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(PAIRS_PER_BATCH);
	localparam int CMP_W  = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
	// Exact mean by reciprocal: floor(n / P) = floor(n * RECIP >> SHIFT) for n < 2^SUM_W
	localparam int SHIFT  = SUM_W + $clog2(PAIRS_PER_BATCH);
	localparam int RCP_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << SHIFT) + 64'(PAIRS_PER_BATCH) - 64'd1) / 64'(PAIRS_PER_BATCH);
	localparam logic [RCP_W-1:0] RECIP = RECIP_WIDE[RCP_W-1:0];
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAIRS_PER_BATCH - 1);

	// Configuration registers
	logic [LEVEL_W-1:0]  thresh_q;
	logic [LEVEL_W-1:0]  span_q;
	logic [WEIGHT_W-1:0] lo_wt_q;
	logic [WEIGHT_W-1:0] hi_wt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= RST_LOW_GAIN_THRESHOLD;
			span_q   <= RST_SETTLE_SPAN;
			lo_wt_q  <= RST_LOW_GAIN_WEIGHT;
			hi_wt_q  <= RST_HIGH_GAIN_WEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_wr_index))
				CFG_LOW_GAIN_THRESHOLD: thresh_q <= cfg_wr_data[LEVEL_W-1:0];
				CFG_SETTLE_SPAN:        span_q   <= cfg_wr_data[LEVEL_W-1:0];
				CFG_LOW_GAIN_WEIGHT:    lo_wt_q  <= cfg_wr_data[WEIGHT_W-1:0];
				CFG_HIGH_GAIN_WEIGHT:   hi_wt_q  <= cfg_wr_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Accumulator state
	logic                   cal_q;
	logic [POS_W-1:0]       pos_q;
	logic [SAMPLE_BITS-1:0] hi_off_q;
	logic [SAMPLE_BITS-1:0] lo_off_q;
	logic [SUM_W-1:0]       hi_sum_q;
	logic [SUM_W-1:0]       lo_sum_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [ENERGY_W-1:0]    lo_tot_q;
	logic [ENERGY_W-1:0]    hi_tot_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic                   valid_s1;

	logic                   out_valid_q;
	logic [ENERGY_W-1:0]    energy_q;
	logic [COUNT_W-1:0]     total_q;
	logic                   cal_out_q;

	logic in_acc;
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_acc   = in_valid && in_ready;

	// Calibration batch: running sums, extremes and batch mean
	logic [SUM_W-1:0]       hi_sum_d;
	logic [SUM_W-1:0]       lo_sum_d;
	logic [SAMPLE_BITS-1:0] min_d;
	logic [SAMPLE_BITS-1:0] max_d;
	logic [PROD_W-1:0]      hi_prod;
	logic [PROD_W-1:0]      lo_prod;
	logic [SAMPLE_BITS-1:0] hi_mean;
	logic [SAMPLE_BITS-1:0] lo_mean;
	logic [SAMPLE_BITS-1:0] spread;
	logic                   settled;
	logic                   batch_end;

	always_comb begin
		if (pos_q == '0) begin
			hi_sum_d = SUM_W'(high_gain_sample);
			lo_sum_d = SUM_W'(low_gain_sample);
			min_d    = high_gain_sample;
			max_d    = high_gain_sample;
		end else begin
			hi_sum_d = hi_sum_q + SUM_W'(high_gain_sample);
			lo_sum_d = lo_sum_q + SUM_W'(low_gain_sample);
			min_d    = min_q;
			max_d    = max_q;
			if (high_gain_sample < min_q) begin
				min_d = high_gain_sample;
			end else if (high_gain_sample > max_q) begin
				max_d = high_gain_sample;
			end
		end
		hi_prod   = PROD_W'(hi_sum_d) * PROD_W'(RECIP);
		lo_prod   = PROD_W'(lo_sum_d) * PROD_W'(RECIP);
		hi_mean   = hi_prod[SHIFT +: SAMPLE_BITS];
		lo_mean   = lo_prod[SHIFT +: SAMPLE_BITS];
		spread    = max_d - min_d;
		settled   = CMP_W'(spread) < CMP_W'(span_q);
		batch_end = (pos_q == LAST_POS);
	end

	// Counting path: pick channel and saturate the offset subtraction
	logic                   use_lo;
	logic                   add_lo;
	logic                   add_hi;
	logic [SAMPLE_BITS-1:0] lo_diff;
	logic [SAMPLE_BITS-1:0] hi_diff;

	always_comb begin
		use_lo  = CMP_W'(low_gain_sample) > CMP_W'(thresh_q);
		add_lo  = use_lo && (low_gain_sample > lo_off_q);
		add_hi  = !use_lo && (high_gain_sample > hi_off_q);
		lo_diff = low_gain_sample - lo_off_q;
		hi_diff = high_gain_sample - hi_off_q;
	end

	// State update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= 1'b0;
			pos_q    <= '0;
			hi_off_q <= '0;
			lo_off_q <= '0;
			hi_sum_q <= '0;
			lo_sum_q <= '0;
			min_q    <= '0;
			max_q    <= '0;
			lo_tot_q <= '0;
			hi_tot_q <= '0;
			cnt_q    <= '0;
		end else if (in_acc) begin
			pos_q <= batch_end ? '0 : pos_q + POS_W'(1);
			if (!cal_q) begin
				hi_sum_q <= hi_sum_d;
				lo_sum_q <= lo_sum_d;
				min_q    <= min_d;
				max_q    <= max_d;
				if (batch_end) begin
					hi_off_q <= hi_mean;
					lo_off_q <= lo_mean;
					if (settled) begin
						cal_q <= 1'b1;
					end
				end
			end else if (conversion_done) begin
				cnt_q <= cnt_q + COUNT_W'(1);
				if (add_lo) begin
					lo_tot_q <= lo_tot_q + ENERGY_W'(lo_diff);
				end else if (add_hi) begin
					hi_tot_q <= hi_tot_q + ENERGY_W'(hi_diff);
				end
			end
		end
	end

	// Stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output register: weight the totals
	logic [ENERGY_W-1:0] lo_energy;
	logic [ENERGY_W-1:0] hi_energy;

	assign lo_energy = lo_tot_q * ENERGY_W'(lo_wt_q);
	assign hi_energy = hi_tot_q * ENERGY_W'(hi_wt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			energy_q  <= lo_energy + hi_energy;
			total_q   <= cnt_q;
			cal_out_q <= cal_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign energy_count  = energy_q;
	assign sample_total  = total_q;
	assign is_calibrated = cal_out_q;

`ifndef ASSERT_OFF
	// Calibration is permanent
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(cal_q))
		else $error("calibrated flag dropped");

	// Nothing is counted before calibration
	a_no_count_uncal: assert property (@(posedge clk) disable iff (!arst_n)
		!cal_q |=> $stable(cnt_q) && $stable(lo_tot_q) && $stable(hi_tot_q))
		else $error("count moved while uncalibrated");

	// Input stalls only when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");

	// Batch position moves only with an accepted beat
	a_pos_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(pos_q))
		else $error("batch position moved without a beat");
`endif

endmodule

>>> bench/tb_dual_gain_energy_accumulator_core.sv
`timescale 1ns / 1ps

module tb_dual_gain_energy_accumulator_core;
	import dgea_pkg::*;

	localparam int DIR_ROWS        = 25;
	localparam int PHASES          = 5;
	localparam int COUNTED_PER_PH  = 180;
	localparam int WATCHDOG_LIMIT  = 500;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [COUNT_W-1:0]  count;
		logic                cal;
	} result_t;

	typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_t;

	// one row of the directed table: either a register write or a sample pair
	typedef struct packed {
		row_kind_t           kind;
		cfg_index_t          addr;
		logic [LEVEL_W-1:0]  data;
		logic [LEVEL_W-1:0]  hi;
		logic [LEVEL_W-1:0]  lo;
		logic                done;
		logic                chk;
		logic [ENERGY_W-1:0] energy;
		logic [COUNT_W-1:0]  count;
		logic                cal;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_wr_index;
	logic [CFG_DATA_W-1:0]  cfg_wr_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [LEVEL_W-1:0]     high_gain_sample;
	logic [LEVEL_W-1:0]     low_gain_sample;
	logic                   conversion_done;
	logic                   out_valid;
	logic                   out_ready;
	logic [ENERGY_W-1:0]    energy_count;
	logic [COUNT_W-1:0]     sample_total;
	logic                   is_calibrated;

	dual_gain_energy_accumulator_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_index     (cfg_wr_index),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.high_gain_sample (high_gain_sample),
		.low_gain_sample  (low_gain_sample),
		.conversion_done  (conversion_done),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.energy_count     (energy_count),
		.sample_total     (sample_total),
		.is_calibrated    (is_calibrated)
	);

	// register copies
	logic [LEVEL_W-1:0]  thr_r;
	logic [LEVEL_W-1:0]  span_r;
	logic [WEIGHT_W-1:0] lw_r;
	logic [WEIGHT_W-1:0] hw_r;

	// accumulator state mirror
	logic                cal_q;
	int                  pos_q;
	int                  hi_sum_q;
	int                  lo_sum_q;
	logic [LEVEL_W-1:0]  hi_off_q;
	logic [LEVEL_W-1:0]  lo_off_q;
	logic [LEVEL_W-1:0]  bmin_q;
	logic [LEVEL_W-1:0]  bmax_q;
	logic [63:0]         lo_tot_q;
	logic [63:0]         hi_tot_q;
	logic [COUNT_W-1:0]  npairs_q;

	result_t             pending_results[$];
	result_t             want;
	row_t                dir_tab [DIR_ROWS];
	result_t             typed_res;

	bit                  idle_on;
	int                  mismatches;
	int                  beats_checked;
	int                  pairs_sent;
	int                  pairs_counted;
	int                  settings_used;
	int                  counted;
	int                  stuck;
	int                  stall_left;
	logic [LEVEL_W-1:0]  r_hi;
	logic [LEVEL_W-1:0]  r_lo;
	logic                r_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mirror of the block: advance state by one accepted pair, return its result
	function automatic result_t predict_energy(logic [LEVEL_W-1:0] hi, logic [LEVEL_W-1:0] lo,
			logic done);
		result_t r;
		if (!cal_q) begin
			// calibration batch: track spread and sums
			if (pos_q == 0) begin
				hi_sum_q = 0;
				lo_sum_q = 0;
				bmin_q = hi;
				bmax_q = hi;
			end else if (hi < bmin_q) begin
				bmin_q = hi;
			end else if (hi > bmax_q) begin
				bmax_q = hi;
			end
			hi_sum_q += int'(hi);
			lo_sum_q += int'(lo);
			if (pos_q == DEF_PAIRS_PER_BATCH - 1) begin
				hi_off_q = LEVEL_W'(hi_sum_q / DEF_PAIRS_PER_BATCH);
				lo_off_q = LEVEL_W'(lo_sum_q / DEF_PAIRS_PER_BATCH);
				if (bmax_q - bmin_q < span_r)
					cal_q = 1'b1;
			end
		end else if (done) begin
			// counting: low-gain channel wins above threshold, differences floor at zero
			if (lo > thr_r) begin
				if (lo > lo_off_q)
					lo_tot_q += 64'(lo - lo_off_q);
			end else if (hi > hi_off_q) begin
				hi_tot_q += 64'(hi - hi_off_q);
			end
			npairs_q += 1;
		end
		pos_q = (pos_q + 1) % DEF_PAIRS_PER_BATCH;
		r.energy = lo_tot_q * 64'(lw_r) + hi_tot_q * 64'(hw_r);
		r.count = npairs_q;
		r.cal = cal_q;
		return r;
	endfunction

	// level near a center, clamped to the sample range
	function automatic logic [LEVEL_W-1:0] near_level(logic [LEVEL_W-1:0] center, int spread);
		int v;
		v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return LEVEL_W'(v);
	endfunction

	// Register write, only once every pending result has drained
	task automatic write_reg(cfg_index_t idx, logic [LEVEL_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		case (idx)
			CFG_LOW_GAIN_THRESHOLD: thr_r = val;
			CFG_SETTLE_SPAN:        span_r = val;
			CFG_LOW_GAIN_WEIGHT:    lw_r = val[WEIGHT_W-1:0];
			CFG_HIGH_GAIN_WEIGHT:   hw_r = val[WEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one pair, hold it until accepted, queue its expected result
	task automatic send_pair(logic [LEVEL_W-1:0] hi, logic [LEVEL_W-1:0] lo, logic done,
			bit use_typed, result_t typed);
		result_t r;
		cfg_wr_en <= 1'b0;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		high_gain_sample <= hi;
		low_gain_sample <= lo;
		conversion_done <= done;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (done && cal_q)
			pairs_counted++;
		r = predict_energy(hi, lo, done);
		pending_results.push_back(use_typed ? typed : r);
		pairs_sent++;
	endtask

	// Result side: random stall bursts on out_ready
	initial begin
		out_ready <= 1'b1;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result beat energy=%h count=%0d cal=%0b",
						$realtime, energy_count, sample_total, is_calibrated);
			end else begin
				want = pending_results.pop_front();
				beats_checked++;
				if (energy_count !== want.energy || sample_total !== want.count ||
						is_calibrated !== want.cal) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp energy %h count %0d cal %0b, got %h %0d %0b",
							$realtime, want.energy, want.count, want.cal,
							energy_count, sample_total, is_calibrated);
				end
			end
		end
	end

	// Watchdog: cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= WATCHDOG_LIMIT) begin
			$display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_index <= CFG_LOW_GAIN_THRESHOLD;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		high_gain_sample <= '0;
		low_gain_sample <= '0;
		conversion_done <= 1'b0;

		thr_r = RST_LOW_GAIN_THRESHOLD;
		span_r = RST_SETTLE_SPAN;
		lw_r = RST_LOW_GAIN_WEIGHT;
		hw_r = RST_HIGH_GAIN_WEIGHT;
		cal_q = 1'b0;
		pos_q = 0;
		hi_sum_q = 0;
		lo_sum_q = 0;
		hi_off_q = '0;
		lo_off_q = '0;
		bmin_q = '0;
		bmax_q = '0;
		lo_tot_q = '0;
		hi_tot_q = '0;
		npairs_q = '0;
		idle_on = 1'b1;
		mismatches = 0;
		beats_checked = 0;
		pairs_sent = 0;
		pairs_counted = 0;
		settings_used = 1;
		stuck = 0;

		// Directed: span 0 never settles (extreme samples); span 4095 settles on a
		// 4094 spread with offsets 2047 / 4000; then each counting path
		dir_tab = '{
			'{ROW_WRITE, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd4095, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd0, 1'b0, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd4095, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd0, 1'b0, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd4095, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd0, 1'b0, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd4095, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd0, 1'b0, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_WRITE, CFG_SETTLE_SPAN, 12'd4095, 12'd0, 12'd0, 1'b0, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4094, 12'd4000, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd4000, 1'b0, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd4000, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd4000, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd4000, 1'b0, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd4000, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd4000, 1'b1, 1'b1, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd4000, 1'b1, 1'b1, 64'd0, 32'd0, 1'b1},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd4095, 1'b1, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd1000, 1'b1, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd390, 1'b1, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd2047, 12'd0, 1'b1, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd4095, 1'b0, 1'b0, 64'd0, 32'd0, 1'b0},
			'{ROW_PAIR, CFG_SETTLE_SPAN, 12'd0, 12'd4095, 12'd4001, 1'b1, 1'b0, 64'd0, 32'd0, 1'b0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_WRITE) begin
				write_reg(dir_tab[i].addr, dir_tab[i].data);
				settings_used++;
			end else begin
				typed_res = '{dir_tab[i].energy, dir_tab[i].count, dir_tab[i].cal};
				send_pair(dir_tab[i].hi, dir_tab[i].lo, dir_tab[i].done, dir_tab[i].chk,
					typed_res);
			end
		end

		// Random phases, one register setting each; the last runs without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_LOW_GAIN_THRESHOLD, 12'd0);
					write_reg(CFG_SETTLE_SPAN, 12'd4095);
					write_reg(CFG_LOW_GAIN_WEIGHT, 12'd255);
					write_reg(CFG_HIGH_GAIN_WEIGHT, 12'd255);
				end
				1: begin
					write_reg(CFG_LOW_GAIN_THRESHOLD, 12'd4095);
					write_reg(CFG_SETTLE_SPAN, 12'd0);
					write_reg(CFG_LOW_GAIN_WEIGHT, 12'd0);
					write_reg(CFG_HIGH_GAIN_WEIGHT, 12'd0);
				end
				2: begin
					write_reg(CFG_LOW_GAIN_THRESHOLD, RST_LOW_GAIN_THRESHOLD);
					write_reg(CFG_SETTLE_SPAN, RST_SETTLE_SPAN);
					write_reg(CFG_LOW_GAIN_WEIGHT, 12'(RST_LOW_GAIN_WEIGHT));
					write_reg(CFG_HIGH_GAIN_WEIGHT, 12'(RST_HIGH_GAIN_WEIGHT));
				end
				default: begin
					write_reg(CFG_LOW_GAIN_THRESHOLD, 12'($urandom_range(0, 4095)));
					write_reg(CFG_SETTLE_SPAN, 12'($urandom_range(0, 4095)));
					write_reg(CFG_LOW_GAIN_WEIGHT, 12'($urandom_range(0, 255)));
					write_reg(CFG_HIGH_GAIN_WEIGHT, 12'($urandom_range(0, 255)));
				end
			endcase
			settings_used++;
			idle_on = (ph < PHASES - 1);
			counted = 0;
			while (counted < COUNTED_PER_PH) begin
				// high-gain: extremes, around the offset, or anywhere
				case ($urandom_range(0, 3))
					0: r_hi = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					1: r_hi = near_level(hi_off_q, 3);
					default: r_hi = 12'($urandom_range(0, 4095));
				endcase
				// low-gain: around threshold, around the offset, extremes, anywhere
				case ($urandom_range(0, 4))
					0: r_lo = near_level(thr_r, 2);
					1: r_lo = near_level(lo_off_q, 2);
					2: r_lo = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					default: r_lo = 12'($urandom_range(0, 4095));
				endcase
				r_done = ($urandom_range(0, 4) != 0);
				send_pair(r_hi, r_lo, r_done, 1'b0, '0);
				if (r_done)
					counted++;
			end
		end

		// drain, then let any stray beat show up
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d sample pairs (%0d counted) across %0d register settings,",
			pairs_sent, pairs_counted, settings_used);
		$display("checked %0d result beats with %0d mismatches.", beats_checked, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/dgea_pkg.sv
rtl/dual_gain_energy_accumulator_core.sv
bench/tb_dual_gain_energy_accumulator_core.sv
